// ===== rtl/core/tnkh_pkg.sv =====
// ----------------------------------------------------------------------------
// tnkh_pkg
// Shared types and codes for the top-N keyed min-heap.
// ----------------------------------------------------------------------------
package tnkh_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int LIMIT_W      = 6;
  localparam int SCORE_W      = 32;
  localparam int KEY_W        = 32;
  localparam int SPELL_W      = 32;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;

  localparam logic FUNC_OFFER = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  localparam logic [1:0] RD_IDX   = 2'd0;
  localparam logic [1:0] RD_PAR   = 2'd1;
  localparam logic [1:0] RD_LEFT  = 2'd2;
  localparam logic [1:0] RD_RIGHT = 2'd3;

  localparam logic [1:0] WR_CUR = 2'd0;
  localparam logic [1:0] WR_RD  = 2'd1;
  localparam logic [1:0] WR_WK  = 2'd2;

  localparam logic [2:0] POS_IDX  = 3'd0;
  localparam logic [2:0] POS_FILL = 3'd1;
  localparam logic [2:0] POS_ZERO = 3'd2;
  localparam logic [2:0] POS_PAR  = 3'd3;
  localparam logic [2:0] POS_WSEL = 3'd4;

  localparam logic [1:0] OUT_OFFER = 2'd0;
  localparam logic [1:0] OUT_ENTRY = 2'd1;
  localparam logic [1:0] OUT_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [KEY_W-1:0]          key;
    logic [SPELL_W-1:0]        spelling;
  } entry_t;

  typedef struct packed {
    logic       ld_in;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_en;
    logic [1:0] rd_sel;
    logic       wr_en;
    logic [1:0] wr_sel;
    logic       pos_ld;
    logic [2:0] pos_sel;
    logic       fill_inc;
    logic       wk_l;
    logic       wk_r;
    logic       best_clr;
    logic       best_upd;
    logic       acc_set;
    logic       out_ld;
    logic [1:0] out_kind;
    logic       drain_fin;
  } tnkh_cmd_t;

  typedef struct packed {
    logic is_drain;
    logic idx_lt_fill;
    logic key_eq;
    logic score_ge;
    logic fill_lt_eff;
    logic cur_le_root;
    logic pos_zero;
    logic cur_weaker_rd;
    logic left_in;
    logic right_in;
    logic wsel_is_pos;
    logic idx_done;
    logic last_emit;
    logic fill_zero;
    logic out_free;
  } tnkh_stat_t;

  function automatic logic weaker(entry_t a, entry_t b);
    if (a.score != b.score) return a.score < b.score;
    if (a.key != b.key) return a.key > b.key;
    return a.spelling > b.spelling;
  endfunction

endpackage

// ===== rtl/core/tnkh_if.sv =====
// ----------------------------------------------------------------------------
// tnkh_if
// Valid/ready channel interfaces for offers/drains and for results.
// ----------------------------------------------------------------------------
interface tnkh_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] cand_score;
  logic [31:0]        group_key;
  logic [31:0]        spelling_handle;
  modport source (output valid, func, cand_score, group_key, spelling_handle, input ready);
  modport sink (input valid, func, cand_score, group_key, spelling_handle, output ready);
endinterface

interface tnkh_out_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               is_full;
  logic signed [31:0] floor_score;
  logic               entry_valid;
  logic signed [31:0] out_score;
  logic [31:0]        out_key;
  logic [31:0]        out_spelling;
  logic               last;
  modport source (output valid, accepted, is_full, floor_score, entry_valid, out_score,
                  out_key, out_spelling, last, input ready);
  modport sink (input valid, accepted, is_full, floor_score, entry_valid, out_score,
                out_key, out_spelling, last, output ready);
endinterface

// ===== rtl/core/tnkh_dp.sv =====
// ----------------------------------------------------------------------------
// tnkh_dp
// Heap memory, working registers, compares and the result register.
// ----------------------------------------------------------------------------
module tnkh_dp import tnkh_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  logic               func,
  input  logic signed [31:0] cand_score,
  input  logic [31:0]        group_key,
  input  logic [31:0]        spelling_handle,
  input  tnkh_cmd_t          cmd,
  output tnkh_stat_t         stat,
  tnkh_out_if.source         out_ch
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = IW + 2;
  localparam int EW = (CW > LIMIT_W) ? CW + 1 : LIMIT_W + 1;

  entry_t mem [CAPACITY];
  entry_t rdata, cur, wk, best, wdata;
  logic [LIMIT_W-1:0] keep_limit;
  logic [CW-1:0] fill, idx, cnt, eff;
  logic [IW-1:0] pos, wsel, bidx, raddr, parent;
  logic [LW-1:0] left_w, right_w;
  logic [CAPACITY-1:0] done;
  logic signed [31:0] root_score;
  logic drain, acc, have_best, full;

  assign parent  = IW'((pos - IW'(1)) >> 1);
  assign left_w  = LW'({pos, 1'b1});
  assign right_w = left_w + LW'(1);
  assign eff = (EW'(keep_limit) >= EW'(CAPACITY)) ? CW'(CAPACITY) :
               (keep_limit == '0) ? CW'(1) : CW'(keep_limit);
  assign full = fill >= eff;

  always_comb begin
    case (cmd.rd_sel)
      RD_IDX:   raddr = IW'(idx);
      RD_PAR:   raddr = parent;
      RD_LEFT:  raddr = IW'(left_w);
      default:  raddr = IW'(right_w);
    endcase
    case (cmd.wr_sel)
      WR_CUR:  wdata = cur;
      WR_RD:   wdata = rdata;
      default: wdata = wk;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) rdata <= mem[raddr];
    if (cmd.wr_en) mem[pos] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= LIMIT_RESET;
      fill <= '0;
      done <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) keep_limit <= cfg_wdata;
      if (cmd.drain_fin) begin
        fill <= '0;
        done <= '0;
      end else begin
        if (cmd.fill_inc) fill <= fill + CW'(1);
        if (cmd.out_ld && cmd.out_kind == OUT_ENTRY) done[bidx] <= 1'b1;
      end
      if (cmd.out_ld) out_ch.valid <= 1'b1;
      else if (out_ch.ready) out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      cur   <= '{score: cand_score, key: group_key, spelling: spelling_handle};
      drain <= func == FUNC_DRAIN;
      acc   <= 1'b0;
      cnt   <= '0;
    end
    if (cmd.acc_set) acc <= 1'b1;
    if (cmd.idx_clr) idx <= '0;
    else if (cmd.idx_inc) idx <= idx + CW'(1);
    if (cmd.wr_en && pos == '0) root_score <= wdata.score;
    if (cmd.pos_ld) begin
      case (cmd.pos_sel)
        POS_IDX:  pos <= IW'(idx);
        POS_FILL: pos <= IW'(fill);
        POS_ZERO: pos <= '0;
        POS_PAR:  pos <= parent;
        default:  pos <= wsel;
      endcase
    end
    if (cmd.wk_l) begin
      if (weaker(rdata, cur)) begin
        wk <= rdata;
        wsel <= IW'(left_w);
      end else begin
        wk <= cur;
        wsel <= pos;
      end
    end
    if (cmd.wk_r && weaker(rdata, wk)) begin
      wk <= rdata;
      wsel <= IW'(right_w);
    end
    if (cmd.best_clr) have_best <= 1'b0;
    if (cmd.best_upd && (!have_best || weaker(best, rdata))) begin
      best <= rdata;
      bidx <= IW'(idx);
      have_best <= 1'b1;
    end
    if (cmd.out_ld) begin
      case (cmd.out_kind)
        OUT_OFFER: begin
          out_ch.accepted     <= acc;
          out_ch.is_full      <= full;
          out_ch.floor_score  <= full ? root_score : SCORE_MIN;
          out_ch.entry_valid  <= 1'b0;
          out_ch.out_score    <= '0;
          out_ch.out_key      <= '0;
          out_ch.out_spelling <= '0;
          out_ch.last         <= 1'b1;
        end
        OUT_ENTRY: begin
          out_ch.accepted     <= 1'b0;
          out_ch.is_full      <= 1'b0;
          out_ch.floor_score  <= SCORE_MIN;
          out_ch.entry_valid  <= 1'b1;
          out_ch.out_score    <= best.score;
          out_ch.out_key      <= best.key;
          out_ch.out_spelling <= best.spelling;
          out_ch.last         <= stat.last_emit;
          cnt <= cnt + CW'(1);
        end
        default: begin
          out_ch.accepted     <= 1'b0;
          out_ch.is_full      <= 1'b0;
          out_ch.floor_score  <= SCORE_MIN;
          out_ch.entry_valid  <= 1'b0;
          out_ch.out_score    <= '0;
          out_ch.out_key      <= '0;
          out_ch.out_spelling <= '0;
          out_ch.last         <= 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    stat.is_drain      = drain;
    stat.idx_lt_fill   = idx < fill;
    stat.key_eq        = rdata.key == cur.key;
    stat.score_ge      = rdata.score >= cur.score;
    stat.fill_lt_eff   = !full;
    stat.cur_le_root   = cur.score <= root_score;
    stat.pos_zero      = pos == '0;
    stat.cur_weaker_rd = weaker(cur, rdata);
    stat.left_in       = left_w < LW'(fill);
    stat.right_in      = right_w < LW'(fill);
    stat.wsel_is_pos   = wsel == pos;
    stat.idx_done      = done[IW'(idx)];
    stat.last_emit     = CW'(cnt + CW'(1)) == fill;
    stat.fill_zero     = fill == '0;
    stat.out_free      = !out_ch.valid || out_ch.ready;
  end

endmodule

// ===== rtl/core/tnkh_ctrl.sv =====
// ----------------------------------------------------------------------------
// tnkh_ctrl
// Sequencer for key search, sift up, sift down and the sorted drain.
// ----------------------------------------------------------------------------
module tnkh_ctrl import tnkh_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  output logic       in_ready,
  input  tnkh_stat_t stat,
  output tnkh_cmd_t  cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SR_RD    = 4'd1;
  localparam logic [3:0] S_SR_CHK   = 4'd2;
  localparam logic [3:0] S_NEW      = 4'd3;
  localparam logic [3:0] S_RISE_RD  = 4'd4;
  localparam logic [3:0] S_RISE_CHK = 4'd5;
  localparam logic [3:0] S_SINK_RL  = 4'd6;
  localparam logic [3:0] S_SINK_RR  = 4'd7;
  localparam logic [3:0] S_SINK_CHK = 4'd8;
  localparam logic [3:0] S_SINK_DEC = 4'd9;
  localparam logic [3:0] S_EMIT_OFF = 4'd10;
  localparam logic [3:0] S_DR_START = 4'd11;
  localparam logic [3:0] S_DR_INIT  = 4'd12;
  localparam logic [3:0] S_DR_RD    = 4'd13;
  localparam logic [3:0] S_DR_CHK   = 4'd14;
  localparam logic [3:0] S_DR_EMIT  = 4'd15;

  logic [3:0] state, state_next;
  logic empty_drain, empty_drain_next;

  assign in_ready = state == S_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      empty_drain <= 1'b0;
    end else begin
      state <= state_next;
      empty_drain <= empty_drain_next;
    end
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    empty_drain_next = empty_drain;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.ld_in = 1'b1;
          cmd.idx_clr = 1'b1;
          empty_drain_next = 1'b0;
          state_next = S_SR_RD;
        end
      end
      S_SR_RD: begin
        if (stat.is_drain) state_next = S_DR_START;
        else if (stat.idx_lt_fill) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_SR_CHK;
        end else state_next = S_NEW;
      end
      S_SR_CHK: begin
        if (stat.key_eq) begin
          if (stat.score_ge) state_next = S_EMIT_OFF;
          else begin
            cmd.acc_set = 1'b1;
            cmd.pos_ld = 1'b1;
            cmd.pos_sel = POS_IDX;
            state_next = S_SINK_RL;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next = S_SR_RD;
        end
      end
      S_NEW: begin
        cmd.pos_ld = 1'b1;
        if (stat.fill_lt_eff) begin
          cmd.acc_set = 1'b1;
          cmd.pos_sel = POS_FILL;
          cmd.fill_inc = 1'b1;
          state_next = S_RISE_RD;
        end else if (stat.cur_le_root) begin
          cmd.pos_ld = 1'b0;
          state_next = S_EMIT_OFF;
        end else begin
          cmd.acc_set = 1'b1;
          cmd.pos_sel = POS_ZERO;
          state_next = S_SINK_RL;
        end
      end
      S_RISE_RD: begin
        if (stat.pos_zero) begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = WR_CUR;
          state_next = S_EMIT_OFF;
        end else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_PAR;
          state_next = S_RISE_CHK;
        end
      end
      S_RISE_CHK: begin
        cmd.wr_en = 1'b1;
        if (stat.cur_weaker_rd) begin
          cmd.wr_sel = WR_RD;
          cmd.pos_ld = 1'b1;
          cmd.pos_sel = POS_PAR;
          state_next = S_RISE_RD;
        end else begin
          cmd.wr_sel = WR_CUR;
          state_next = S_EMIT_OFF;
        end
      end
      S_SINK_RL: begin
        if (stat.left_in) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_LEFT;
          state_next = S_SINK_RR;
        end else begin
          cmd.wr_en = 1'b1;
          cmd.wr_sel = WR_CUR;
          state_next = S_EMIT_OFF;
        end
      end
      S_SINK_RR: begin
        cmd.wk_l = 1'b1;
        if (stat.right_in) begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_RIGHT;
          state_next = S_SINK_CHK;
        end else state_next = S_SINK_DEC;
      end
      S_SINK_CHK: begin
        cmd.wk_r = 1'b1;
        state_next = S_SINK_DEC;
      end
      S_SINK_DEC: begin
        cmd.wr_en = 1'b1;
        if (stat.wsel_is_pos) begin
          cmd.wr_sel = WR_CUR;
          state_next = S_EMIT_OFF;
        end else begin
          cmd.wr_sel = WR_WK;
          cmd.pos_ld = 1'b1;
          cmd.pos_sel = POS_WSEL;
          state_next = S_SINK_RL;
        end
      end
      S_EMIT_OFF: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.out_kind = empty_drain ? OUT_EMPTY : OUT_OFFER;
          state_next = S_IDLE;
        end
      end
      S_DR_START: begin
        if (stat.fill_zero) begin
          empty_drain_next = 1'b1;
          state_next = S_EMIT_OFF;
        end else state_next = S_DR_INIT;
      end
      S_DR_INIT: begin
        cmd.idx_clr = 1'b1;
        cmd.best_clr = 1'b1;
        state_next = S_DR_RD;
      end
      S_DR_RD: begin
        if (!stat.idx_lt_fill) state_next = S_DR_EMIT;
        else if (stat.idx_done) cmd.idx_inc = 1'b1;
        else begin
          cmd.rd_en = 1'b1;
          cmd.rd_sel = RD_IDX;
          state_next = S_DR_CHK;
        end
      end
      S_DR_CHK: begin
        cmd.best_upd = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next = S_DR_RD;
      end
      S_DR_EMIT: begin
        if (stat.out_free) begin
          cmd.out_ld = 1'b1;
          cmd.out_kind = OUT_ENTRY;
          if (stat.last_emit) begin
            cmd.drain_fin = 1'b1;
            state_next = S_IDLE;
          end else state_next = S_DR_INIT;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/top_n_keyed_min_heap_top.sv =====
// ----------------------------------------------------------------------------
// top_n_keyed_min_heap_top
// Keeps the best N keyed, scored candidates in a binary min-heap.
//
//   channel  dir  handshake     beat
//   in_ch    in   valid/ready   func, cand_score, group_key, spelling_handle
//   out_ch   out  valid/ready   accepted .. last (one beat per result)
//   cfg      in   cfg_we        keep_limit
//
// Offer: a search of the stored slots, then sift up or sift down level by
// level, all on the heap memory's single read port.
// Drain of n entries: a selection scan per beat.
// Reset empties the store; no clearing pass. Output stalls hold the sequencer
// only when a new result is ready; the input is taken again once idle.
// ----------------------------------------------------------------------------
module top_n_keyed_min_heap_top import tnkh_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  tnkh_in_if.sink            in_ch,
  tnkh_out_if.source         out_ch
);

  tnkh_cmd_t  cmd;
  tnkh_stat_t stat;
  logic       in_rdy;

  assign in_ch.ready = in_rdy;

  tnkh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_ch.valid && in_rdy),
    .in_ready (in_rdy),
    .stat     (stat),
    .cmd      (cmd)
  );

  tnkh_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .func            (in_ch.func),
    .cand_score      (in_ch.cand_score),
    .group_key       (in_ch.group_key),
    .spelling_handle (in_ch.spelling_handle),
    .cmd             (cmd),
    .stat            (stat),
    .out_ch          (out_ch)
  );

`ifndef SYNTHESIS
  a_rst_idle: assert property (@(posedge clk) rst |=> !out_ch.valid && in_ch.ready)
    else $error("not idle after reset");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("second item taken while busy");
  a_entry_fields: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.entry_valid |-> !out_ch.accepted && !out_ch.is_full)
    else $error("drain beat carries offer status");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> stat.out_free)
    else $error("result register overwritten");
`endif

endmodule
